[rtl/core/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// Simpson sample integrator package
// Shared widths and constants for the integrator core and its scaling unit.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // Sample and step words, both Q16.16.
    localparam int SAMPLE_W = 32;
    localparam int STEP_W   = 32;

    // Running sum of one data set.
    localparam int SUM_W    = 48;

    // Weighted sum in 48ths of a sample. Its magnitude stays below 2^53.
    localparam int W48_W    = 56;

    // Product of the weighted-sum magnitude and the step.
    localparam int PROD_W   = W48_W + STEP_W;

    // Result word, Q32.32.
    localparam int RES_W    = 64;

    // Half of the divisor 48, added before the divide for round to nearest.
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(24);

    // The divide by 48 is a shift by four and then a divide by three, one
    // byte of the dividend per step.
    localparam int DIV_SHIFT = 4;
    localparam int DIGIT_W   = 8;
    localparam int DIV_STEPS = PROD_W / DIGIT_W;

    // Reset value of the step register, 1.0 in Q16.16.
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    // Saturation limits of the result.
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

endpackage

[rtl/core/ssi_scale.sv]
// ----------------------------------------------------------------------------
// Simpson integrator scaling unit
// Multiplies a signed weighted sum by the step, divides by 48 with rounding
// to nearest (ties away from zero) and saturates to the Q32.32 range.
// ----------------------------------------------------------------------------
module ssi_scale
    import ssi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [W48_W-1:0]        i_w48,
    input  logic [STEP_W-1:0]       i_step,
    output logic                    o_done,
    output logic [RES_W-1:0]        o_result
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL_LO = 6'b000010,
        S_MUL_HI = 6'b000100,
        S_ROUND  = 6'b001000,
        S_DIV    = 6'b010000,
        S_SAT    = 6'b100000
    } t_scale_state;

    localparam int CNT_W = $clog2(DIV_STEPS);

    // One byte of a divide by three: two remainder bits in and out.
    function automatic logic [DIGIT_W+1:0] div3_digit(
        input logic [1:0]         rem_in,
        input logic [DIGIT_W-1:0] digit
    );
        logic [2:0]         rem;
        logic [DIGIT_W-1:0] quo;
        rem = {1'b0, rem_in};
        quo = '0;
        for (int b = DIGIT_W - 1; b >= 0; b--) begin
            rem = {rem[1:0], digit[b]};
            if (rem >= 3'd3) begin
                quo[b] = 1'b1;
                rem    = rem - 3'd3;
            end
        end
        return {rem[1:0], quo};
    endfunction

    t_scale_state      r_state, n_state;
    logic              r_neg;
    logic [W48_W-1:0]  r_mag;
    logic [PROD_W-1:0] r_acc;
    logic [1:0]        r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [RES_W-1:0]  r_result;

    logic [STEP_W-1:0]    mul_a;
    logic [2*STEP_W-1:0]  mul_p;
    logic [PROD_W-1:0]    biased;
    logic [DIGIT_W+1:0]   digit_out;
    logic                 big;
    logic [RES_W-1:0]     sat_val;

    // The single multiplier takes the low word first and the high part second.
    assign mul_a = (r_state == S_MUL_LO) ? r_mag[STEP_W-1:0]
                                         : STEP_W'(r_mag[W48_W-1:STEP_W]);
    assign mul_p = mul_a * i_step;

    assign biased    = r_acc + ROUND_BIAS;
    assign digit_out = div3_digit(r_rem, r_acc[PROD_W-1 -: DIGIT_W]);

    assign big     = |r_acc[PROD_W-1:RES_W-1];
    assign sat_val = big   ? (r_neg ? RES_MIN : RES_MAX)
                   : r_neg ? (RES_W'(0) - r_acc[RES_W-1:0])
                   : r_acc[RES_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_MUL_LO;
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_ROUND;
            S_ROUND:  n_state = S_DIV;
            S_DIV:    if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_SAT;
            S_SAT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_SAT);
            if (r_state == S_ROUND) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV && r_cnt != CNT_W'(DIV_STEPS - 1)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_neg <= i_w48[W48_W-1];
                r_mag <= i_w48[W48_W-1] ? (W48_W'(0) - i_w48) : i_w48;
            end
            S_MUL_LO: begin
                r_acc <= PROD_W'(mul_p);
            end
            S_MUL_HI: begin
                r_acc <= r_acc + {mul_p[PROD_W-STEP_W-1:0], {STEP_W{1'b0}}};
            end
            S_ROUND: begin
                r_acc <= {{DIV_SHIFT{1'b0}}, biased[PROD_W-1:DIV_SHIFT]};
                r_rem <= 2'd0;
            end
            S_DIV: begin
                r_acc <= {r_acc[PROD_W-DIGIT_W-1:0], digit_out[DIGIT_W-1:0]};
                r_rem <= digit_out[DIGIT_W+1:DIGIT_W];
            end
            S_SAT: begin
                r_result <= sat_val;
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DIV_STEPS - 1))
        else $error("divide step count out of range");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> ##14 (r_state == S_SAT))
        else $error("scaling did not reach saturation step on time");

endmodule

[rtl/core/simpson_sample_integrator.sv]
// ----------------------------------------------------------------------------
// Simpson sample integrator
// Integrates equally spaced samples by the extended Simpson rule and returns
// the Q32.32 integral on the sample marked as the last of a data set.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload            Direction
//  -------   -----------------------   ----------------   ---------
//  input     i_valid / o_stall         i_sample,          in
//                                      i_last_sample
//  output    o_valid / i_stall         o_integral         out
//  config    i_cfg_valid / o_cfg_ready i_step_size        in
//
//  A sample that is not marked last leaves the control in T_IDLE, and the next
//  word can follow in the next cycle.
//  A marked sample holds o_stall high while the block loads the sum, runs up
//  to four weighting steps, starts the scaling unit and waits for it (the two
//  passes through the shared 32x32 multiplier, a rounding step, eleven byte
//  steps of the divide-by-three unit and a saturation step), and then until
//  the result has been handed over to the output register.
//  A finished result waits in the output register; new samples are taken
//  while it is stalled, and only the next result waits for it to leave.
//  Reset is synchronous and active low; it clears the running sum, the count
//  and the control state and sets the step to 1.0.
//
module simpson_sample_integrator
    import ssi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_W-1:0]     i_sample,
    input  logic                    i_last_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [RES_W-1:0]        o_integral,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [STEP_W-1:0]       i_step_size
);

    // Control sequence for one data set. Plain samples never leave T_IDLE.
    typedef enum logic [5:0] {
        T_IDLE  = 6'b000001,
        T_SUM   = 6'b000010,
        T_TERM  = 6'b000100,
        T_START = 6'b001000,
        T_WAIT  = 6'b010000,
        T_DONE  = 6'b100000
    } t_state;

    localparam int TERM_W = 40;
    localparam logic [3:0] COUNT_FULL = 4'd8;

    // End correction for one pair of head and tail samples, in 48ths.
    // With eight or more points the corrections are -31, +11, -5 and +1;
    // with two to seven points only the outer pair gets -24.
    function automatic logic [TERM_W-1:0] end_term(
        input logic [SAMPLE_W:0] pair,
        input logic [1:0]        idx,
        input logic              full
    );
        logic [TERM_W-1:0] p;
        logic [TERM_W-1:0] t;
        p = {{(TERM_W-SAMPLE_W-1){pair[SAMPLE_W]}}, pair};
        if (!full) begin
            t = TERM_W'(0) - ((p << 4) + (p << 3));
        end else begin
            unique case (idx)
                2'd0:    t = p - (p << 5);
                2'd1:    t = (p << 3) + (p << 1) + p;
                2'd2:    t = TERM_W'(0) - ((p << 2) + p);
                default: t = p;
            endcase
        end
        return t;
    endfunction

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_sum;
    logic [3:0]         r_count;
    logic [SAMPLE_W-1:0] r_head [4];
    logic [SAMPLE_W-1:0] r_tail [4];
    logic [W48_W-1:0]   r_acc;
    logic [1:0]         r_k;
    logic               r_full;
    logic               r_out_valid;
    logic [RES_W-1:0]   r_integral;

    logic               in_take;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   n_sum;
    logic [W48_W-1:0]   sum_ext;
    logic [SAMPLE_W:0]  pair;
    logic [TERM_W-1:0]  term;
    logic               out_free;
    logic               scale_done;
    logic [RES_W-1:0]   scale_result;

    assign o_stall     = (r_state != T_IDLE);
    assign o_cfg_ready = (r_state == T_IDLE);
    assign in_take     = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;

    // Saturating add of the new sample into the running sum.
    assign sum_wide = {r_sum[SUM_W-1], r_sum}
                    + {{(SUM_W-SAMPLE_W+1){i_sample[SAMPLE_W-1]}}, i_sample};
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                    : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = sum_wide[SUM_W-1:0];
        end
    end

    assign sum_ext = {{(W48_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
    assign pair    = {r_head[r_k][SAMPLE_W-1], r_head[r_k]}
                   + {r_tail[r_k][SAMPLE_W-1], r_tail[r_k]};
    assign term    = end_term(pair, r_k, r_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  if (in_take && i_last_sample) n_state = T_SUM;
            T_SUM:   n_state = (r_count >= 4'd2) ? T_TERM : T_START;
            T_TERM:  if (!r_full || r_k == 2'd3) n_state = T_START;
            T_START: n_state = T_WAIT;
            T_WAIT:  if (scale_done) n_state = T_DONE;
            T_DONE:  if (out_free) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    // Control state, running sum, count, step and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_step      <= STEP_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_step <= i_step_size;
            end
            if (in_take) begin
                r_sum <= n_sum;
                if (r_count < COUNT_FULL) begin
                    r_count <= r_count + 4'd1;
                end
            end else if (r_state == T_SUM) begin
                // The set has been captured; the next sample starts a new one.
                r_sum   <= '0;
                r_count <= '0;
            end
            if (r_state == T_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sample stores and the weighted-sum accumulator.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            if (r_count < 4'd4) begin
                r_head[r_count[1:0]] <= i_sample;
            end
            r_tail[3] <= r_tail[2];
            r_tail[2] <= r_tail[1];
            r_tail[1] <= r_tail[0];
            r_tail[0] <= i_sample;
        end
        if (r_state == T_SUM) begin
            r_acc  <= (sum_ext << 5) + (sum_ext << 4);
            r_k    <= 2'd0;
            r_full <= (r_count >= COUNT_FULL);
        end else if (r_state == T_TERM) begin
            r_acc <= r_acc + {{(W48_W-TERM_W){term[TERM_W-1]}}, term};
            r_k   <= r_k + 2'd1;
        end
        if (r_state == T_DONE && out_free) begin
            r_integral <= scale_result;
        end
    end

    ssi_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == T_START),
        .i_w48    (r_acc),
        .i_step   (r_step),
        .o_done   (scale_done),
        .o_result (scale_result)
    );

    assign o_valid    = r_out_valid;
    assign o_integral = r_integral;

    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_last_sample) |=> o_stall)
        else $error("marked sample did not start the result sequence");

    a_plain_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !i_last_sample) |=> !o_stall)
        else $error("plain sample did not return to idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("point count beyond saturation");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scale_done |-> (r_state == T_WAIT))
        else $error("scaling result arrived outside the wait state");

endmodule

[tb/simpson_sample_integrator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simpson sample integrator checker
// Watches the sample, result and step channels, predicts the integral of each
// data set from the accepted words and compares it with the returned word.
// ----------------------------------------------------------------------------
module simpson_sample_integrator_checker
    import ssi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_sample,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [RES_W-1:0]    i_integral,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [STEP_W-1:0]   i_step_size,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic signed [63:0] SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SUM_LO = -(64'sd1 <<< (SUM_W - 1));

    logic signed [SUM_W-1:0]    sum_q;
    logic signed [SAMPLE_W-1:0] head_q [4];
    logic signed [SAMPLE_W-1:0] tail_q [4];
    logic [3:0]                 count_q;
    logic [STEP_W-1:0]          step_q;
    logic [RES_W-1:0]           integral_q [$];

    // Rounds the weighted sum (in 48ths) times the step to the nearest Q32.32
    // value, ties away from zero, and saturates it.
    function automatic logic [RES_W-1:0] scale_by_step(input logic signed [63:0] w48,
                                                       input logic [STEP_W-1:0] step);
        logic [127:0] mag;
        logic [127:0] quo;
        mag = (w48 < 0) ? 128'(-w48) : 128'(w48);
        quo = (mag * 128'(step) + 128'd24) / 128'd48;
        if (w48 >= 0)
            return (quo > 128'(RES_MAX)) ? RES_MAX : quo[RES_W-1:0];
        return (quo > 128'(RES_MAX)) ? RES_MIN : (~quo[RES_W-1:0] + 64'd1);
    endfunction

    always @(posedge i_clk) begin : track
        logic signed [63:0] acc;
        logic signed [63:0] pair [4];
        logic signed [63:0] weighted;
        logic [RES_W-1:0]   want;
        if (!i_rst_n) begin
            sum_q        = '0;
            count_q      = '0;
            step_q       = STEP_RESET;
            o_fail_count = 0;
            integral_q.delete();
        end else begin
            // A result leaving at this edge is older than any sample taken at it.
            if (i_out_valid && !i_out_stall) begin
                if (integral_q.size() == 0) begin
                    $error("integral: no result expected, actual %h", i_integral);
                    o_fail_count++;
                end else begin
                    want = integral_q.pop_front();
                    if (i_integral !== want) begin
                        $error("integral: expected %h, actual %h", want, i_integral);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                step_q = i_step_size;
            if (i_in_valid && !i_in_stall) begin
                if (count_q < 4)
                    head_q[count_q[1:0]] = i_sample;
                tail_q[3] = tail_q[2];
                tail_q[2] = tail_q[1];
                tail_q[1] = tail_q[0];
                tail_q[0] = i_sample;
                if (count_q < 8)
                    count_q = count_q + 4'd1;
                acc = 64'(sum_q) + 64'($signed(i_sample));
                if (acc > SUM_HI)
                    acc = SUM_HI;
                else if (acc < SUM_LO)
                    acc = SUM_LO;
                sum_q = acc[SUM_W-1:0];
                if (i_last_sample) begin
                    for (int k = 0; k < 4; k++)
                        pair[k] = 64'(head_q[k]) + 64'(tail_q[k]);
                    // End weights minus one, in 48ths: -31, +11, -5, +1.
                    weighted = 48 * acc;
                    if (count_q >= 8)
                        weighted = weighted - 31 * pair[0] + 11 * pair[1]
                                 - 5 * pair[2] + pair[3];
                    else if (count_q >= 2)
                        weighted = weighted - 24 * pair[0];
                    integral_q.push_back(scale_by_step(weighted, step_q));
                    sum_q   = '0;
                    count_q = '0;
                end
            end
        end
        o_pending = integral_q.size();
    end

endmodule

[tb/simpson_sample_integrator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simpson sample integrator testbench
// Drives data sets of samples through the integrator under several step
// settings and idling patterns; a separate checker predicts each integral.
// ----------------------------------------------------------------------------
module simpson_sample_integrator_tb;
    import ssi_pkg::*;

    // Idling patterns of the sample sender and the result receiver.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [STEP_W-1:0]   STEP_MAX   = '1;

    localparam int PHASE_WORDS    = 200;
    localparam int HOLD_CYCLES    = 400;
    // A marked sample keeps the block busy until it has handed its result over.
    localparam int DRAIN_CYCLES   = 40;
    // Longest quiet stretch is the receiver hold-off, well below this.
    localparam int QUIET_LIMIT    = 4000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample;
    logic                i_last_sample;
    logic                o_valid;
    logic                i_stall;
    logic [RES_W-1:0]    o_integral;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [STEP_W-1:0]   i_step_size;

    int mismatch_count;
    int results_pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_done     = 0;
    int quiet_cycles  = 0;

    simpson_sample_integrator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_integral    (o_integral),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_step_size   (i_step_size)
    );

    simpson_sample_integrator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_integral    (o_integral),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_step_size   (i_step_size),
        .o_fail_count  (mismatch_count),
        .o_pending     (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Result receiver. It stalls at random at the current rate, and on request
    // holds off for a long stretch so that the block fills up and stalls its
    // own input while the sender keeps offering words.
    initial begin : receiver
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = hold_req;
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // The run ends as failed once no word has moved on any channel for too
    // long, which also catches a result that never arrives.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL simpson_sample_integrator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one sample word, after a random gap when the sender idles, and
    // returns at the falling edge after the word was taken. Valid stays high
    // so that a following word can go out without a bubble.
    task automatic put_word(input logic [SAMPLE_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sample      <= value;
        i_last_sample <= last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // One data set with a mix of full-scale, small and fully random samples.
    task automatic put_set(input int len);
        logic [SAMPLE_W-1:0] value;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0:       value = SAMPLE_MAX;
                1:       value = SAMPLE_MIN;
                2, 3:    value = $urandom_range(32'h0003_FFFF) - 32'h0002_0000;
                default: value = $urandom();
            endcase
            put_word(value, k == len - 1);
        end
    endtask

    // Stops sending and waits until every expected integral has left, then
    // lets the block finish any work still in flight.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // The step register is only written while the block is idle.
    task automatic write_step(input logic [STEP_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_step_size <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          placed;
        int          len;
        t_idle_mode  mode;
        logic [STEP_W-1:0] step;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_last_sample = 1'b0;
        i_cfg_valid   = 1'b0;
        i_step_size   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A single point under the reset step of 1.0.
        put_word(32'h0001_8000, 1'b1);

        // Full-scale step: single points at both extremes, a two-point set,
        // eight- and nine-point sets that saturate the result both ways, and a three-point set.
        write_step(STEP_MAX);
        put_word(SAMPLE_MAX, 1'b1);
        put_word(SAMPLE_MIN, 1'b1);
        put_word(SAMPLE_MAX, 1'b0);
        put_word(SAMPLE_MIN, 1'b1);
        repeat (7) put_word(SAMPLE_MAX, 1'b0);
        put_word(SAMPLE_MAX, 1'b1);
        repeat (8) put_word(SAMPLE_MIN, 1'b0);
        put_word(SAMPLE_MIN, 1'b1);
        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'h0000_0001, 1'b0);
        put_word(32'h0000_0000, 1'b1);

        // Receiver hold-off while short sets keep coming, then a full pause.
        write_step(STEP_RESET);
        hold_req++;
        repeat (24) put_set($urandom_range(1, 3));
        wait_drained();

        // Random phases, each under its own step and idling pattern. Short
        // and medium sets dominate; a few run up to 64 points.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0, 6:    step = STEP_MAX;
                1:       step = '0;
                2:       step = 32'h0000_0001;
                4:       step = STEP_RESET;
                5:       step = $urandom_range(1, 32'h0004_0000);
                default: step = $urandom();
            endcase
            write_step(step);
            mode = t_idle_mode'(ph % 4);
            case (mode)
                IDLE_SENDER: begin
                    send_idle_pct = 79;
                    stall_pct     = 0;
                end
                IDLE_RECEIVER: begin
                    send_idle_pct = 0;
                    stall_pct     = 79;
                end
                IDLE_BOTH: begin
                    send_idle_pct = 8;
                    stall_pct     = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            placed = 0;
            while (placed < PHASE_WORDS) begin
                case ($urandom_range(9))
                    0:          len = 1;
                    1:          len = 2;
                    7, 8:       len = $urandom_range(8, 24);
                    9:          len = $urandom_range(25, 64);
                    default:    len = $urandom_range(3, 12);
                endcase
                put_set(len);
                placed += len;
            end
        end

        wait_drained();
        if (mismatch_count == 0 && results_pending == 0)
            $display("PASS simpson_sample_integrator");
        else
            $display("FAIL simpson_sample_integrator");
        $finish;
    end

endmodule
